// ----- sv/knn_pkg.sv -----
// shared constants, codes and types of the three-nearest-neighbor voter
`timescale 1ns / 1ps
package knn_pkg;

  localparam int DIM          = 488;
  localparam int SLOTS        = 10;
  localparam int FEATURE_BITS = 16;

  localparam int ADDR_W = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int POS_W  = $clog2(DIM + 1);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int MAG_W  = FEATURE_BITS + 1;
  localparam int SQ_W   = 2 * FEATURE_BITS + 2;
  localparam int DIST_W = 48;
  localparam int LAB_W  = 8;
  localparam int VLAB_W = 9;

  localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};
  localparam logic [VLAB_W-1:0] EMPTY_LABEL = 9'h100;

  typedef enum logic [1:0] {
    OP_LEARN = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_PRED    = 2'd0,
    ST_STORED  = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef struct packed {
    logic sq_en;
    logic acc_en;
    logic acc_clr;
    logic acc_add;
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- sv/knn_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module knn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 488,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/knn_cell.sv -----
// one exemplar slot: feature memory, label, squared distance accumulator
`timescale 1ns / 1ps
module knn_cell (
  input  logic                                     clk,
  input  knn_pkg::cell_ctl_t                       ctl,
  input  logic signed [knn_pkg::FEATURE_BITS-1:0]  feat_d1,
  input  logic                                     ram_we,
  input  logic [knn_pkg::ADDR_W-1:0]               ram_addr,
  input  logic [knn_pkg::FEATURE_BITS-1:0]         ram_wdata,
  input  logic                                     lab_we,
  input  logic [knn_pkg::LAB_W-1:0]                lab_in,
  input  logic [knn_pkg::DIST_W-1:0]               dist_in,
  input  logic [knn_pkg::LAB_W-1:0]                slab_in,
  output logic [knn_pkg::DIST_W-1:0]               dist_out,
  output logic [knn_pkg::LAB_W-1:0]                slab_out
);

  logic [knn_pkg::FEATURE_BITS-1:0] rdata;
  logic signed [knn_pkg::MAG_W-1:0] diff;
  logic [knn_pkg::MAG_W-1:0]        mag;
  logic [knn_pkg::SQ_W-1:0]         mag_ext;
  logic [knn_pkg::SQ_W-1:0]         sq;
  logic [knn_pkg::SQ_W-1:0]         sq_r;
  logic [knn_pkg::DIST_W-1:0]       acc_r;
  logic [knn_pkg::DIST_W-1:0]       base;
  logic [knn_pkg::DIST_W:0]         sum;
  logic [knn_pkg::DIST_W-1:0]       acc_nxt;
  logic [knn_pkg::LAB_W-1:0]        lab_r;
  logic [knn_pkg::LAB_W-1:0]        slab_r;

  knn_ram #(
    .WIDTH(knn_pkg::FEATURE_BITS),
    .DEPTH(knn_pkg::DIM)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(ram_wdata),
    .raddr(ram_addr),
    .rdata(rdata)
  );

  always_comb begin
    diff    = knn_pkg::MAG_W'(feat_d1) - knn_pkg::MAG_W'(signed'(rdata));
    mag     = diff[knn_pkg::MAG_W-1] ? knn_pkg::MAG_W'(-diff) : knn_pkg::MAG_W'(diff);
    mag_ext = knn_pkg::SQ_W'(mag);
    sq      = mag_ext * mag_ext;
    base    = ctl.acc_clr ? '0 : acc_r;
    sum     = {1'b0, base} + (ctl.acc_add ? (knn_pkg::DIST_W + 1)'(sq_r) : '0);
    // saturate at the all-ones distance
    acc_nxt = sum[knn_pkg::DIST_W] ? knn_pkg::DIST_MAX : sum[knn_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.sq_en) begin
      sq_r <= sq;
    end
    if (lab_we) begin
      lab_r <= lab_in;
    end
    if (ctl.shift) begin
      acc_r  <= dist_in;
      slab_r <= slab_in;
    end else begin
      if (ctl.acc_en) begin
        acc_r <= acc_nxt;
      end
      if (ctl.load) begin
        slab_r <= lab_r;
      end
    end
  end

  assign dist_out = acc_r;
  assign slab_out = slab_r;

endmodule

// ----- sv/knn_top3.sv -----
// running three-nearest insertion and binary majority vote
`timescale 1ns / 1ps
module knn_top3 (
  input  logic                        clk,
  input  logic                        init,
  input  logic                        en,
  input  logic [knn_pkg::DIST_W-1:0]  cand_dist,
  input  logic [knn_pkg::LAB_W-1:0]   lab,
  output logic                        pred
);

  logic [knn_pkg::DIST_W-1:0] d_r [3];
  logic [knn_pkg::VLAB_W-1:0] l_r [3];
  logic [knn_pkg::VLAB_W-1:0] lab_ext;
  logic [1:0]                 yes;
  logic [1:0]                 no;

  assign lab_ext = knn_pkg::VLAB_W'(lab);

  always_ff @(posedge clk) begin
    if (init) begin
      for (int j = 0; j < 3; j++) begin
        d_r[j] <= knn_pkg::DIST_MAX;
        l_r[j] <= knn_pkg::EMPTY_LABEL;
      end
    end else if (en) begin
      if (cand_dist < d_r[0]) begin
        d_r[2] <= d_r[1];
        l_r[2] <= l_r[1];
        d_r[1] <= d_r[0];
        l_r[1] <= l_r[0];
        d_r[0] <= cand_dist;
        l_r[0] <= lab_ext;
      end else if (cand_dist < d_r[1]) begin
        d_r[2] <= d_r[1];
        l_r[2] <= l_r[1];
        d_r[1] <= cand_dist;
        l_r[1] <= lab_ext;
      end else if (cand_dist < d_r[2]) begin
        d_r[2] <= cand_dist;
        l_r[2] <= lab_ext;
      end
    end
  end

  always_comb begin
    yes = '0;
    no  = '0;
    for (int j = 0; j < 3; j++) begin
      if (l_r[j] == knn_pkg::VLAB_W'(1)) yes = yes + 2'd1;
      if (l_r[j] == '0) no = no + 2'd1;
    end
    pred = (yes > no);
  end

endmodule

// ----- sv/knn_three_nearest_binary_vote.sv -----
// top level: element stream control, chain of slot cells, nearest-three vote
// results: learn and clear results are registered, valid in the cycle after
//   the beat; a query result follows the drain, load and select states
// throughput: one feature beat per cycle within a vector unless stalled; a
//   query's last beat blocks input until the chain has passed the selector
// reset: synchronous active-low rst_n clears control, count and position;
//   exemplar memories and labels are undefined until written
`timescale 1ns / 1ps
module knn_three_nearest_binary_vote (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_op,
  input  logic signed [15:0]                 in_feature,
  input  logic [7:0]                         in_label,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_prediction,
  output logic [1:0]                         out_status,
  output logic [3:0]                         out_stored_count
);

  typedef enum logic [1:0] {S_RUN, S_DRAIN, S_LOAD, S_SELECT} state_t;

  state_t                                   state_r;
  logic [knn_pkg::POS_W-1:0]                pos_r;
  logic [knn_pkg::CNT_W-1:0]                total_r;
  logic [knn_pkg::CNT_W-1:0]                sel_cnt_r;
  logic                                     v1_r, q1_r, c1_r;
  logic                                     v2_r, q2_r, c2_r;
  logic signed [knn_pkg::FEATURE_BITS-1:0]  f1_r;
  logic                                     out_valid_r;
  logic                                     out_pred_r;
  logic [1:0]                               out_status_r;
  logic [3:0]                               out_count_r;

  logic                                     accept;
  logic                                     elem;
  logic                                     in_range;
  logic signed [knn_pkg::FEATURE_BITS-1:0]  feat;
  logic [knn_pkg::ADDR_W-1:0]               addr;
  logic                                     full;
  logic                                     pred;
  logic                                     sel_done;
  knn_pkg::cell_ctl_t                       ctl;
  logic [knn_pkg::DIST_W-1:0]               dist_chain [knn_pkg::SLOTS+1];
  logic [knn_pkg::LAB_W-1:0]                lab_chain  [knn_pkg::SLOTS+1];

  assign in_ready = (state_r == S_RUN) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign elem     = accept && ((in_op == knn_pkg::OP_LEARN) || (in_op == knn_pkg::OP_QUERY));
  assign in_range = (pos_r < knn_pkg::POS_W'(knn_pkg::DIM));
  assign feat     = signed'(in_feature[knn_pkg::FEATURE_BITS-1:0]);
  assign addr     = pos_r[knn_pkg::ADDR_W-1:0];
  assign full     = (total_r >= knn_pkg::CNT_W'(knn_pkg::SLOTS));
  assign sel_done = (sel_cnt_r == total_r);

  always_comb begin
    ctl.sq_en   = v1_r;
    ctl.acc_en  = v2_r;
    ctl.acc_clr = c2_r;
    ctl.acc_add = q2_r;
    ctl.load    = (state_r == S_LOAD);
    ctl.shift   = (state_r == S_SELECT) && !sel_done;
  end

  assign dist_chain[knn_pkg::SLOTS] = '0;
  assign lab_chain[knn_pkg::SLOTS]  = '0;

  for (genvar i = 0; i < knn_pkg::SLOTS; i++) begin : g_cell
    knn_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .feat_d1  (f1_r),
      .ram_we   (elem && (in_op == knn_pkg::OP_LEARN) && in_range
                 && (total_r == knn_pkg::CNT_W'(i))),
      .ram_addr (addr),
      .ram_wdata(feat),
      .lab_we   (elem && (in_op == knn_pkg::OP_LEARN) && in_last
                 && (total_r == knn_pkg::CNT_W'(i))),
      .lab_in   (in_label),
      .dist_in  (dist_chain[i+1]),
      .slab_in  (lab_chain[i+1]),
      .dist_out (dist_chain[i]),
      .slab_out (lab_chain[i])
    );
  end

  knn_top3 u_top3 (
    .clk      (clk),
    .init     (ctl.load),
    .en       (ctl.shift),
    .cand_dist(dist_chain[0]),
    .lab      (lab_chain[0]),
    .pred     (pred)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      pos_r       <= '0;
      total_r     <= '0;
      sel_cnt_r   <= '0;
      v1_r        <= 1'b0;
      q1_r        <= 1'b0;
      c1_r        <= 1'b0;
      v2_r        <= 1'b0;
      q2_r        <= 1'b0;
      c2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // accumulate pipeline: ram read, square, add
      v1_r <= elem;
      q1_r <= elem && (in_op == knn_pkg::OP_QUERY) && in_range;
      c1_r <= (pos_r == '0);
      f1_r <= feat;
      v2_r <= v1_r;
      q2_r <= q1_r;
      c2_r <= c1_r;

      case (state_r)
        S_RUN: begin
          if (accept && (in_op == knn_pkg::OP_CLEAR)) begin
            total_r      <= '0;
            pos_r        <= '0;
            out_valid_r  <= 1'b1;
            out_pred_r   <= 1'b0;
            out_status_r <= knn_pkg::ST_CLEARED;
            out_count_r  <= '0;
          end else if (elem) begin
            if (in_range) begin
              pos_r <= pos_r + 1'b1;
            end
            if (in_last) begin
              pos_r <= '0;
              if (in_op == knn_pkg::OP_LEARN) begin
                out_valid_r <= 1'b1;
                out_pred_r  <= 1'b0;
                if (!full) begin
                  total_r      <= total_r + 1'b1;
                  out_status_r <= knn_pkg::ST_STORED;
                  out_count_r  <= 4'(total_r + 1'b1);
                end else begin
                  out_status_r <= knn_pkg::ST_FULL;
                  out_count_r  <= 4'(total_r);
                end
              end else begin
                state_r <= S_DRAIN;
              end
            end
          end
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          sel_cnt_r <= '0;
          state_r   <= S_SELECT;
        end
        S_SELECT: begin
          if (sel_done) begin
            out_valid_r  <= 1'b1;
            out_pred_r   <= pred;
            out_status_r <= knn_pkg::ST_PRED;
            out_count_r  <= 4'(total_r);
            state_r      <= S_RUN;
          end else begin
            sel_cnt_r <= sel_cnt_r + 1'b1;
          end
        end
        default: begin
          state_r <= S_RUN;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_prediction   = out_pred_r;
  assign out_status       = out_status_r;
  assign out_stored_count = out_count_r;

endmodule

// ----- sv/knn_checker.sv -----
// port-level checks of the voter, bound to the top level
`timescale 1ns / 1ps
module knn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_prediction,
  input logic [1:0]  out_status,
  input logic [3:0]  out_stored_count
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_stored_count) && $stable(out_prediction))
    else $error("result beat changed while stalled");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == knn_pkg::ST_CLEARED) |-> (out_stored_count == 4'd0))
    else $error("clear result with nonzero count");

  a_pred_only_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != knn_pkg::ST_PRED) |-> !out_prediction)
    else $error("prediction set on non-query result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_stored_count <= 4'(knn_pkg::SLOTS)))
    else $error("stored count beyond slot count");

  a_clear_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == knn_pkg::OP_CLEAR) |=> out_valid
      && (out_status == knn_pkg::ST_CLEARED))
    else $error("clear beat gave no clear result");

endmodule

bind knn_three_nearest_binary_vote knn_checker u_knn_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_prediction  (out_prediction),
  .out_status      (out_status),
  .out_stored_count(out_stored_count)
);
